// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_I(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// property must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_I(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)

`endif

`endif

// ===== hw/rtl/ssx_pkg.sv =====
`default_nettype none

package ssx_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KEY0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_START = 3'd5;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // word indexes a, b, c, d of each quarter-round lane, column half then row half
  localparam logic [3:0] QR_IDX [2][4][4] = '{
    '{ '{4'd0,  4'd4,  4'd8,  4'd12},
       '{4'd5,  4'd9,  4'd13, 4'd1 },
       '{4'd10, 4'd14, 4'd2,  4'd6 },
       '{4'd15, 4'd3,  4'd7,  4'd11} },
    '{ '{4'd0,  4'd1,  4'd2,  4'd3 },
       '{4'd5,  4'd6,  4'd7,  4'd4 },
       '{4'd10, 4'd11, 4'd8,  4'd9 },
       '{4'd15, 4'd12, 4'd13, 4'd14} }
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } ssx_state_e;

  typedef struct packed {
    logic       in_ready;
    logic       in_accept;  // word taken on the input this cycle
    logic       direct;     // word accepted and answered from the current block
    logic       load_init;
    logic       round_en;
    logic       half;       // 0 column round, 1 row round
    logic [1:0] step;       // step inside the quarter-round
    logic       feed;
    logic       emit;
  } ssx_cmd_t;

  typedef struct packed {
    logic need_block;
    logic out_free;
  } ssx_status_t;

  // rotate for each quarter-round step
  function automatic logic [31:0] qr_rot(input logic [31:0] v, input logic [1:0] step);
    logic [31:0] r;
    case (step)
      2'd0:    r = {v[24:0], v[31:25]};
      2'd1:    r = {v[22:0], v[31:23]};
      2'd2:    r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssx_in_if.sv =====
`default_nettype none

interface ssx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssx_out_if.sv =====
`default_nettype none

interface ssx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssx_ctrl.sv =====
`default_nettype none

module ssx_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire ssx_pkg::ssx_status_t status_i,
  output ssx_pkg::ssx_cmd_t        cmd_o
);
  import ssx_pkg::*;

  localparam int unsigned RndW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [RndW-1:0] RndLast = RndW'(DOUBLE_ROUNDS - 1);

  ssx_state_e      state_q, state_d;
  logic [1:0]      step_q, step_d;
  logic            half_q, half_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            in_ready;
  logic            accept;
  logic            rounds_done;

  assign in_ready    = (state_q == ST_IDLE) && status_i.out_free;
  assign accept      = in_ready && in_valid_i;
  assign rounds_done = (rnd_q == RndLast) && half_q && (step_q == 2'd3);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && status_i.need_block) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (rounds_done) state_d = ST_FEED;
      ST_FEED:  state_d = ST_EMIT;
      ST_EMIT:  if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // round counters: step, then half, then double round
  always_comb begin
    step_d = step_q;
    half_d = half_q;
    rnd_d  = rnd_q;
    if (state_q == ST_LOAD) begin
      step_d = 2'd0;
      half_d = 1'b0;
      rnd_d  = '0;
    end else if (state_q == ST_ROUND) begin
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        half_d = ~half_q;
        if (half_q) rnd_d = rnd_q + RndW'(1);
      end
    end
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.in_ready  = in_ready;
    cmd_o.in_accept = accept;
    cmd_o.half      = half_q;
    cmd_o.step      = step_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.direct    = accept && !status_i.need_block;
      ST_LOAD:  cmd_o.load_init = 1'b1;
      ST_ROUND: cmd_o.round_en  = 1'b1;
      ST_FEED:  cmd_o.feed      = 1'b1;
      ST_EMIT:  cmd_o.emit      = status_i.out_free;
      default:  cmd_o.direct    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
      half_q  <= 1'b0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      half_q  <= half_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssx_datapath.sv =====
`default_nettype none

module ssx_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ssx_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          first_byte_i,
  input  wire logic                          last_byte_i,
  input  wire logic                          out_ready_i,
  input  wire ssx_pkg::ssx_cmd_t             cmd_i,
  output ssx_pkg::ssx_status_t               status_o,
  output logic                               out_valid_o,
  output logic [7:0]                         out_byte_o,
  output logic                               last_out_o
);
  import ssx_pkg::*;

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q, start_q;
  logic [63:0] key0_d, key1_d, key2_d, key3_d, nonce_d, start_d;
  logic [63:0] ctr_q, ctr_d;
  logic [5:0]  off_q, off_d;
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] ks_q [16];
  logic [31:0] ks_d [16];
  logic [31:0] init_w [16];
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q, olast_d;
  logic        ovalid_q, ovalid_d;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign status_o.out_free   = !ovalid_q || out_ready_i;
  assign status_o.need_block = first_byte_i || (off_q == 6'd0);

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign last_out_o  = olast_q;

  assign ks_word = ks_q[off_q[5:2]];
  assign ks_byte = ks_word[{off_q[1:0], 3'b000} +: 8];

  // block input words
  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = key0_q[31:0];
    init_w[2]  = key0_q[63:32];
    init_w[3]  = key1_q[31:0];
    init_w[4]  = key1_q[63:32];
    init_w[5]  = SIGMA1;
    init_w[6]  = nonce_q[31:0];
    init_w[7]  = nonce_q[63:32];
    init_w[8]  = ctr_q[31:0];
    init_w[9]  = ctr_q[63:32];
    init_w[10] = SIGMA2;
    init_w[11] = key2_q[31:0];
    init_w[12] = key2_q[63:32];
    init_w[13] = key3_q[31:0];
    init_w[14] = key3_q[63:32];
    init_w[15] = SIGMA3;
  end

  // config writes
  always_comb begin
    key0_d  = key0_q;
    key1_d  = key1_q;
    key2_d  = key2_q;
    key3_d  = key3_q;
    nonce_d = nonce_q;
    start_d = start_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0:  key0_d  = cfg_data_i;
        CFG_KEY1:  key1_d  = cfg_data_i;
        CFG_KEY2:  key2_d  = cfg_data_i;
        CFG_KEY3:  key3_d  = cfg_data_i;
        CFG_NONCE: nonce_d = cfg_data_i;
        CFG_START: start_d = cfg_data_i;
        default:   start_d = start_q;
      endcase
    end
  end

  // four quarter-round lanes, one add-rotate-xor step each per cycle
  always_comb begin
    logic [1:0]  sn, sp;
    logic [3:0]  ti, xi, yi;
    logic [31:0] sum;
    sn  = cmd_i.step + 2'd1;
    sp  = cmd_i.step + 2'd3;
    ti  = '0;
    xi  = '0;
    yi  = '0;
    sum = '0;
    w_d = w_q;
    if (cmd_i.load_init) begin
      w_d = init_w;
    end else if (cmd_i.round_en) begin
      for (int l = 0; l < 4; l++) begin
        ti  = QR_IDX[cmd_i.half][l][sn];
        xi  = QR_IDX[cmd_i.half][l][cmd_i.step];
        yi  = QR_IDX[cmd_i.half][l][sp];
        sum = w_q[xi] + w_q[yi];
        w_d[ti] = w_q[ti] ^ qr_rot(sum, cmd_i.step);
      end
    end
  end

  // feed-forward, counter and offset
  always_comb begin
    ks_d  = ks_q;
    ctr_d = ctr_q;
    off_d = off_q;
    if (cmd_i.feed) begin
      for (int i = 0; i < 16; i++) ks_d[i] = w_q[i] + init_w[i];
      ctr_d = ctr_q + 64'd1;
    end
    if (cmd_i.in_ready && cmd_i.direct) off_d = off_q + 6'd1;
    if (cmd_i.emit) off_d = off_q + 6'd1;
    if (cmd_i.load_init) off_d = 6'd0;
    // first byte restarts the message
    if (cmd_i.in_accept && first_byte_i) begin
      ctr_d = start_q;
    end
  end

  // held word and result register
  always_comb begin
    data_d   = data_q;
    last_d   = last_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !out_ready_i;
    if (cmd_i.in_ready) begin
      data_d = data_byte_i;
      last_d = last_byte_i;
    end
    if (cmd_i.direct) begin
      obyte_d  = data_byte_i ^ ks_byte;
      olast_d  = last_byte_i;
      ovalid_d = 1'b1;
    end else if (cmd_i.emit) begin
      obyte_d  = data_q ^ ks_byte;
      olast_d  = last_q;
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q   <= '0;
      key1_q   <= '0;
      key2_q   <= '0;
      key3_q   <= '0;
      nonce_q  <= '0;
      start_q  <= '0;
      ctr_q    <= '0;
      off_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      key0_q   <= key0_d;
      key1_q   <= key1_d;
      key2_q   <= key2_d;
      key3_q   <= key3_d;
      nonce_q  <= nonce_d;
      start_q  <= start_d;
      ctr_q    <= ctr_d;
      off_q    <= off_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    ks_q    <= ks_d;
    data_q  <= data_d;
    last_q  <= last_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/salsa20_stream_xor.sv =====
// salsa20/20 keystream xor, one message byte per word
//
// in_i carries data_byte with first_byte and last_byte; out_o returns
// out_byte = data_byte xor keystream byte, with last_out copied from last_byte.
// key, nonce and start counter are written on the cfg port (index 0..5); the
// user must write them only while idle, which the block does not enforce.
// a byte that starts a keystream block (first_byte set, or offset 0 in the
// block) is held while the block is made: a load state, the round states
// (four quarter-round lanes, one add-rotate-xor step per cycle), a feed-forward
// state and an emit state that waits for a free output register.
// the other 63 bytes of a block are answered from the stored block in the
// cycle they are accepted: one byte per cycle while out_o.ready is high,
// result valid on the next cycle. the single output register frees in the
// same cycle out_o.ready takes it, so a stalled receiver holds the result
// and stops new bytes until it is taken. reset clears the key, nonce, counter
// and offset to zero; the first byte after reset always makes a new block.
`default_nettype none

`include "assert_macros.svh"

module salsa20_stream_xor #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ssx_pkg::CfgDataW-1:0]  cfg_data_i,
  ssx_in_if.sink                             in_i,
  ssx_out_if.source                          out_o
);
  import ssx_pkg::*;

  ssx_cmd_t    cmd;
  ssx_status_t status;
  logic        in_accept;

  assign in_i.ready = cmd.in_ready;
  assign in_accept  = in_i.valid && cmd.in_ready;

  ssx_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ssx_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .data_byte_i (in_i.data_byte),
    .first_byte_i(in_i.first_byte),
    .last_byte_i (in_i.last_byte),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .last_out_o  (out_o.last_out)
  );

  `ASSERT_I(a_block_stops_input, clk_i, rst_ni, (in_accept && status.need_block) |=> !in_i.ready)
  `ASSERT_NEVER(a_no_accept_in_rounds, clk_i, rst_ni, cmd.round_en && in_i.ready)
  `ASSERT_I(a_result_has_source, clk_i, rst_ni, $rose(out_o.valid) |-> $past(cmd.direct || cmd.emit))
  `ASSERT_I(a_feed_then_emit, clk_i, rst_ni, cmd.feed |=> !cmd.round_en && !cmd.in_ready)

endmodule

`default_nettype wire
